/* design/rai_pkg.sv */
// shared types and constants for the ray versus box intersection core
package rai_pkg;

  localparam int DW         = 32;  // coordinate and distance width
  localparam int FRAC       = 16;  // fraction bits of Q16.16
  localparam int NAXIS      = 3;
  localparam int NFACE      = 6;
  localparam int NREG       = 6;
  localparam int AW         = 5;   // byte address width of the register port
  localparam int QDEPTH_DEF = 4;
  localparam int PW         = 49;  // dir * t / 2^16, signed
  localparam int HW         = 50;  // origin + shifted product, signed

  typedef logic [NAXIS-1:0][DW-1:0] rai_vec_t;

  typedef struct packed {
    logic                         in_box;
    logic [NFACE-1:0]             elig;
    logic [NAXIS-1:0][DW-1:0]     org;
    logic [NAXIS-1:0][DW-1:0]     dir;
    logic [DW-1:0]                len;
    logic                         unb;
  } rai_meta_t;

  typedef struct packed {
    rai_meta_t                    meta;
    logic [NFACE-1:0][DW-1:0]     num;
    logic [NFACE-1:0][DW-1:0]     den;
  } rai_item_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [DW-1:0] den;
    logic [DW-1:0] low;
    logic [DW-1:0] quo;
    logic          sat;
  } rai_div_t;

endpackage

/* design/ray_aabb_intersect_core.sv */
// top level of the ray versus axis-aligned box intersection core
//
// Tests one ray (origin, direction, length, all Q16.16) per transfer on the in_
// channel against the box held in six registers on the register port
// (box_min_x/y/z at 0x00..0x08, box_max_x/y/z at 0x0c..0x14). One result
// (hit, distance) leaves on the out_ channel for every ray, in order.
// A transfer happens when valid is high and stall is low.
// A ray passes the queue, the 32-stage face dividers (one quotient bit per
// stage, six in parallel), then the multiply, bounds check, pair pick and
// output stages. The pipeline advances one ray per cycle while out_ does
// not stall.
// A stall on out_ freezes the whole arithmetic pipeline; the 4-entry queue
// behind the front end keeps taking rays until it fills, then in_stall rises.
// Reset clears the box registers to zero and empties queue and pipeline.
// Write the registers only while no ray is in flight.
module ray_aabb_intersect_core #(
  parameter int QueueDepth = rai_pkg::QDEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [rai_pkg::DW-1:0] in_origin_x,
  input  logic [rai_pkg::DW-1:0] in_origin_y,
  input  logic [rai_pkg::DW-1:0] in_origin_z,
  input  logic [rai_pkg::DW-1:0] in_dir_x,
  input  logic [rai_pkg::DW-1:0] in_dir_y,
  input  logic [rai_pkg::DW-1:0] in_dir_z,
  input  logic [rai_pkg::DW-1:0] in_ray_length,
  input  logic                   in_length_unbounded,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output logic [rai_pkg::DW-1:0] out_distance,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [rai_pkg::AW-1:0] paddr,
  input  logic [rai_pkg::DW-1:0] pwdata,
  output logic [rai_pkg::DW-1:0] prdata,
  output logic                   pready
);
  import rai_pkg::*;

  logic [DW-1:0]   box_r [NREG];
  logic [AW-3:0]   reg_idx;
  rai_vec_t        box_lo, box_hi;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        box_r[i] <= '0;
      end
    end else if (psel && penable && pwrite && (reg_idx < (AW-2)'(NREG))) begin
      box_r[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < (AW-2)'(NREG)) begin
      prdata = box_r[reg_idx];
    end
  end

  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      box_lo[a] = box_r[a];
      box_hi[a] = box_r[a+NAXIS];
    end
  end

  rai_item_t item;
  rai_item_t q_data;
  logic      q_full, q_valid, q_pop, push;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  rai_front u_front (
    .in_origin_x         (in_origin_x),
    .in_origin_y         (in_origin_y),
    .in_origin_z         (in_origin_z),
    .in_dir_x            (in_dir_x),
    .in_dir_y            (in_dir_y),
    .in_dir_z            (in_dir_z),
    .in_ray_length       (in_ray_length),
    .in_length_unbounded (in_length_unbounded),
    .box_lo              (box_lo),
    .box_hi              (box_hi),
    .item                (item)
  );

  rai_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (item),
    .pop       (q_pop),
    .rd_data   (q_data),
    .full      (q_full),
    .not_empty (q_valid)
  );

  rai_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .box_lo       (box_lo),
    .box_hi       (box_hi),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit      (out_hit),
    .out_distance (out_distance)
  );

endmodule

/* design/rai_front.sv */
// front end: classifies a ray against the box and prepares face divisions
module rai_front (
  input  logic [rai_pkg::DW-1:0]  in_origin_x,
  input  logic [rai_pkg::DW-1:0]  in_origin_y,
  input  logic [rai_pkg::DW-1:0]  in_origin_z,
  input  logic [rai_pkg::DW-1:0]  in_dir_x,
  input  logic [rai_pkg::DW-1:0]  in_dir_y,
  input  logic [rai_pkg::DW-1:0]  in_dir_z,
  input  logic [rai_pkg::DW-1:0]  in_ray_length,
  input  logic                    in_length_unbounded,
  input  rai_pkg::rai_vec_t       box_lo,
  input  rai_pkg::rai_vec_t       box_hi,
  output rai_pkg::rai_item_t      item
);
  import rai_pkg::*;

  rai_vec_t org;
  rai_vec_t dir;
  logic [NAXIS-1:0] in_lo;
  logic [NAXIS-1:0] in_hi;

  assign org = {in_origin_z, in_origin_y, in_origin_x};
  assign dir = {in_dir_z, in_dir_y, in_dir_x};

  always_comb begin
    item = '0;
    item.meta.org = org;
    item.meta.dir = dir;
    item.meta.len = in_ray_length;
    item.meta.unb = in_length_unbounded;
    for (int a = 0; a < NAXIS; a++) begin
      in_lo[a] = $signed(org[a]) > $signed(box_lo[a]);
      in_hi[a] = $signed(org[a]) < $signed(box_hi[a]);
      // lower face: origin on the outer side, moving up
      item.meta.elig[2*a] = ($signed(org[a]) <= $signed(box_lo[a])) && ($signed(dir[a]) > 0);
      item.num[2*a]       = box_lo[a] - org[a];
      item.den[2*a]       = dir[a];
      // upper face: origin on the outer side, moving down
      item.meta.elig[2*a+1] = ($signed(org[a]) >= $signed(box_hi[a])) && ($signed(dir[a]) < 0);
      item.num[2*a+1]       = org[a] - box_hi[a];
      item.den[2*a+1]       = '0 - dir[a];
    end
    item.meta.in_box = (&in_lo) && (&in_hi);
  end

endmodule

/* design/rai_queue.sv */
// short queue between the front end and the arithmetic pipeline
module rai_queue #(
  parameter int Depth = rai_pkg::QDEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  rai_pkg::rai_item_t  wr_data,
  input  logic                pop,
  output rai_pkg::rai_item_t  rd_data,
  output logic                full,
  output logic                not_empty
);
  import rai_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rai_item_t       mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full      = (count_r == CntW'(Depth));
  assign not_empty = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* design/rai_divider.sv */
// pipelined restoring divider, one quotient bit per stage, saturating at all ones
module rai_divider (
  input  logic                   clk,
  input  logic                   en,
  input  logic [rai_pkg::DW-1:0] num,
  input  logic [rai_pkg::DW-1:0] den,
  output logic [rai_pkg::DW-1:0] quo
);
  import rai_pkg::*;

  rai_div_t init_s;
  rai_div_t stage_r [DW];

  // dividend is num * 2^16; its top part is already below den unless saturated
  always_comb begin
    init_s.rem = {{FRAC{1'b0}}, num[DW-1:FRAC]};
    init_s.den = den;
    init_s.low = {num[FRAC-1:0], {FRAC{1'b0}}};
    init_s.quo = '0;
    init_s.sat = ({{FRAC{1'b0}}, num} >= {den, {FRAC{1'b0}}});
  end

  for (genvar i = 0; i < DW; i++) begin : g_stage
    rai_div_t        cur;
    rai_div_t        nxt;
    logic [DW+1:0]   diff;

    if (i == 0) begin : g_first
      assign cur = init_s;
    end else begin : g_rest
      assign cur = stage_r[i-1];
    end

    always_comb begin
      diff     = {1'b0, cur.rem, cur.low[DW-1]} - {2'b00, cur.den};
      nxt      = cur;
      nxt.low  = {cur.low[DW-2:0], 1'b0};
      if (!diff[DW+1]) begin
        nxt.rem = diff[DW-1:0];
        nxt.quo = {cur.quo[DW-2:0], 1'b1};
      end else begin
        nxt.rem = {cur.rem[DW-2:0], cur.low[DW-1]};
        nxt.quo = {cur.quo[DW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[i] <= nxt;
      end
    end
  end

  assign quo = stage_r[DW-1].sat ? '1 : stage_r[DW-1].quo;

endmodule

/* design/rai_back.sv */
// back end: face divisions, hit point checks, nearest face pick and output register
module rai_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  rai_pkg::rai_item_t     q_data,
  output logic                   q_pop,
  input  rai_pkg::rai_vec_t      box_lo,
  input  rai_pkg::rai_vec_t      box_hi,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output logic [rai_pkg::DW-1:0] out_distance
);
  import rai_pkg::*;

  logic adv;
  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  // division stages, metadata travels alongside
  logic [NFACE-1:0][DW-1:0] t_s;
  rai_meta_t                meta_r [DW];
  logic [DW-1:0]            vld_r;

  for (genvar f = 0; f < NFACE; f++) begin : g_div
    rai_divider u_div (
      .clk (clk),
      .en  (adv),
      .num (q_data.num[f]),
      .den (q_data.den[f]),
      .quo (t_s[f])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= q_data.meta;
      for (int i = 1; i < DW; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DW-2:0], q_valid};
    end
  end

  // multiply stage: other-axis offsets of the hit point
  logic [PW-1:0]            prod_r [NFACE][2];
  logic [NFACE-1:0][DW-1:0] tm_r;
  rai_meta_t                mmeta_r;
  logic                     mvld_r;

  // compare stage
  logic [NFACE-1:0]         ok_s;
  logic [NFACE-1:0]         ok_r;
  logic [NFACE-1:0][DW-1:0] tc_r;
  logic                     cinside_r, cunb_r;
  logic [DW-1:0]            clen_r;
  logic                     cvld_r;

  for (genvar f = 0; f < NFACE; f++) begin : g_face
    localparam int A  = f / 2;
    localparam int K0 = (A == 0) ? 1 : 0;
    localparam int K1 = (A == 2) ? 1 : 2;
    localparam int KS [2] = '{K0, K1};

    logic [1:0] in_s;

    for (genvar j = 0; j < 2; j++) begin : g_other
      logic signed [2*DW:0] prod;
      logic signed [2*DW:0] psh;
      logic        [HW-1:0] h;
      logic        [PW-1:0] p;
      logic        [DW-1:0] o;

      assign prod = $signed(meta_r[DW-1].dir[KS[j]]) * $signed({1'b0, t_s[f]});
      assign psh  = prod >>> FRAC;

      always_ff @(posedge clk) begin
        if (adv) begin
          prod_r[f][j] <= psh[PW-1:0];
        end
      end

      assign p = prod_r[f][j];
      assign o = mmeta_r.org[KS[j]];
      assign h = {{(HW-DW){o[DW-1]}}, o} + {{(HW-PW){p[PW-1]}}, p};
      assign in_s[j] =
        ($signed(h) >= $signed({{(HW-DW){box_lo[KS[j]][DW-1]}}, box_lo[KS[j]]})) &&
        ($signed(h) <= $signed({{(HW-DW){box_hi[KS[j]][DW-1]}}, box_hi[KS[j]]}));
    end

    assign ok_s[f] = mmeta_r.elig[f] && (&in_s);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tm_r      <= t_s;
      mmeta_r   <= meta_r[DW-1];
      ok_r      <= ok_s;
      tc_r      <= tm_r;
      cinside_r <= mmeta_r.in_box;
      cunb_r    <= mmeta_r.unb;
      clen_r    <= mmeta_r.len;
    end
  end

  // pair stage: nearer of the two faces of each axis, earlier face on a tie
  logic [NAXIS-1:0]          pok_s, pok_r;
  logic [NAXIS-1:0][DW-1:0]  pt_s, pt_r;
  logic                      pinside_r, punb_r;
  logic [DW-1:0]             plen_r;
  logic                      pvld_r;

  always_comb begin
    for (int a = 0; a < NAXIS; a++) begin
      if (ok_r[2*a] && (!ok_r[2*a+1] || (tc_r[2*a] <= tc_r[2*a+1]))) begin
        pok_s[a] = 1'b1;
        pt_s[a]  = tc_r[2*a];
      end else begin
        pok_s[a] = ok_r[2*a+1];
        pt_s[a]  = tc_r[2*a+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pok_r     <= pok_s;
      pt_r      <= pt_s;
      pinside_r <= cinside_r;
      punb_r    <= cunb_r;
      plen_r    <= clen_r;
    end
  end

  // final pick, length limit and output register
  logic          hit_s, best_ok;
  logic [DW-1:0] best_t;
  logic          hit_r;
  logic [DW-1:0] dist_r;
  logic          ovld_r;

  always_comb begin
    best_ok = pok_r[0];
    best_t  = pt_r[0];
    for (int a = 1; a < NAXIS; a++) begin
      if (pok_r[a] && (!best_ok || (pt_r[a] < best_t))) begin
        best_ok = 1'b1;
        best_t  = pt_r[a];
      end
    end
    hit_s = best_ok && (punb_r || (best_t <= plen_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r  <= pinside_r || hit_s;
      dist_r <= (!pinside_r && hit_s) ? best_t : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r <= 1'b0;
      cvld_r <= 1'b0;
      pvld_r <= 1'b0;
      ovld_r <= 1'b0;
    end else if (adv) begin
      mvld_r <= vld_r[DW-1];
      cvld_r <= mvld_r;
      pvld_r <= cvld_r;
      ovld_r <= pvld_r;
    end
  end

  assign out_valid    = ovld_r;
  assign out_hit      = hit_r;
  assign out_distance = dist_r;

endmodule
